/* hdl/odo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel odometry package
// Shared widths, constants, the job record between front and back, the
// sequencer states and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package odo_pkg;

	localparam int TICK_W    = 32;
	localparam int STAMP_W   = 32;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int POS_W     = 32;
	localparam int HEAD_W    = 31;
	localparam int VEL_W     = 32;
	localparam int TRAVEL_W  = 32;
	localparam int DELTA_W   = 34;

	localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_TICK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK_WIDTH = 2'd1;

	localparam logic [CFG_W-1:0] DIST_PER_TICK_RST   = 24'd85648;
	localparam logic [CFG_W-1:0] INV_TRACK_WIDTH_RST = 24'd327680;

	localparam int WINDOW_DEF  = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam int ANG_W      = 42;
	localparam int WRAP_STEPS = 11;
	localparam logic [ANG_W-1:0] PI_U     = 42'd843314857;
	localparam logic [ANG_W-1:0] TWO_PI_U = 42'd1686629714;

	localparam int CORDIC_W     = 34;
	localparam int CORDIC_STEPS = 28;
	localparam logic signed [CORDIC_W-1:0] CORDIC_K  = 34'sd652032874;
	localparam logic signed [CORDIC_W-1:0] PI_C      = 34'sd843314857;
	localparam logic signed [CORDIC_W-1:0] HALF_PI_C = 34'sd421657428;

	localparam int TURN_MAG_W = 40;
	localparam logic [TRAVEL_W-2:0] TRAVEL_LIMIT = {(TRAVEL_W-1){1'b1}};
	localparam logic [TURN_MAG_W-1:0] TURN_LIMIT = {TURN_MAG_W{1'b1}};

	localparam int QBITS     = 31;
	localparam int MILLION_W = 20;
	localparam logic [MILLION_W-1:0] MILLION = 20'd1000000;
	localparam logic [QBITS-1:0] VEL_LIMIT = {QBITS{1'b1}};

	typedef struct packed {
		logic signed [DELTA_W-1:0] sum;
		logic signed [DELTA_W-1:0] diff;
		logic [STAMP_W-1:0]        dt;
		logic                      has_dt;
	} odo_job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_PREP,
		ST_WRAP,
		ST_FOLD,
		ST_CORDIC,
		ST_MUL4,
		ST_ACC
	} odo_state_t;

	function automatic logic signed [CORDIC_W-1:0] atan_step(input logic [4:0] i);
		logic signed [CORDIC_W-1:0] a;
		case (i)
			5'd0: a = 34'sd210828714;
			5'd1: a = 34'sd124459457;
			5'd2: a = 34'sd65760959;
			5'd3: a = 34'sd33381290;
			5'd4: a = 34'sd16755422;
			5'd5: a = 34'sd8385879;
			5'd6: a = 34'sd4193963;
			5'd7: a = 34'sd2097109;
			5'd8: a = 34'sd1048571;
			5'd9: a = 34'sd524287;
			default: a = CORDIC_W'(1) <<< (5'd28 - i);
		endcase
		return a;
	endfunction

endpackage

/* hdl/odo_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry front end
// Accepts tick requests, forms wrapped wheel deltas, side sums and the time
// delta, and queues a job; the first request after reset only latches.
// ----------------------------------------------------------------------------
module odo_front
	import odo_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [TICK_W-1:0] ticks_front_left,
	input  logic signed [TICK_W-1:0] ticks_rear_left,
	input  logic signed [TICK_W-1:0] ticks_front_right,
	input  logic signed [TICK_W-1:0] ticks_rear_right,
	input  logic [STAMP_W-1:0]       stamp_us,
	input  logic                     q_full,
	output logic                     q_push,
	output odo_job_t                 q_data
);

	logic                     first_q;
	logic signed [TICK_W-1:0] prev_fl_q, prev_rl_q, prev_fr_q, prev_rr_q;
	logic [STAMP_W-1:0]       prev_stamp_q;
	logic signed [TICK_W-1:0] d_fl, d_rl, d_fr, d_rr;
	logic signed [TICK_W:0]   side_l, side_r;
	logic [STAMP_W-1:0]       dt;
	logic                     take;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	always_comb begin
		d_fl   = ticks_front_left - prev_fl_q;
		d_rl   = ticks_rear_left - prev_rl_q;
		d_fr   = ticks_front_right - prev_fr_q;
		d_rr   = ticks_rear_right - prev_rr_q;
		side_l = (TICK_W+1)'(d_fl) + (TICK_W+1)'(d_rl);
		side_r = (TICK_W+1)'(d_fr) + (TICK_W+1)'(d_rr);
		dt     = stamp_us - prev_stamp_q;
		q_data.sum    = DELTA_W'(side_l) + DELTA_W'(side_r);
		q_data.diff   = DELTA_W'(side_r) - DELTA_W'(side_l);
		q_data.dt     = dt;
		q_data.has_dt = (dt != '0);
		q_push        = take && !first_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (take) begin
			first_q <= 1'b0;
		end
	end

	// latch counts and time on every request
	always_ff @(posedge clk) begin
		if (take) begin
			prev_fl_q    <= ticks_front_left;
			prev_rl_q    <= ticks_rear_left;
			prev_fr_q    <= ticks_front_right;
			prev_rr_q    <= ticks_rear_right;
			prev_stamp_q <= stamp_us;
		end
	end

endmodule

/* hdl/odo_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry job queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module odo_queue
	import odo_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  odo_job_t push_data,
	output logic     full,
	input  logic     pop,
	output odo_job_t pop_data,
	output logic     empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	odo_job_t          mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

/* hdl/odo_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry velocity divider
// Scales a windowed sum by one million and divides it by the windowed time,
// rounding half away from zero, one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module odo_div
	import odo_pkg::*;
#(
	parameter int SUM_W = 35
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] num,
	input  logic [SUM_W-1:0]        den,
	output logic                    busy,
	output logic signed [VEL_W-1:0] quot
);

	localparam int PROD_W = SUM_W + MILLION_W;
	localparam int N_W    = PROD_W + 1;
	localparam int HI_W   = N_W - QBITS;

	logic [SUM_W-1:0]  mag;
	logic [PROD_W-1:0] prod;
	logic [N_W-1:0]    n_full;
	logic [SUM_W-1:0]  hi_ext;
	logic [SUM_W:0]    trial;
	logic              fit;
	logic [QBITS-1:0]  q_mag;

	logic              busy_q, init_q, neg_q, sat_q;
	logic [N_W-1:0]    n_q;
	logic [SUM_W-1:0]  den_q, rem_q;
	logic [QBITS-1:0]  nlow_q, quo_q;
	logic [4:0]        cnt_q;

	always_comb begin
		mag    = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
		prod   = PROD_W'(mag) * PROD_W'(MILLION);
		n_full = N_W'(prod) + N_W'(den >> 1);
		hi_ext = SUM_W'(n_q[N_W-1:QBITS]);
		trial  = {rem_q, nlow_q[QBITS-1]};
		fit    = (trial >= {1'b0, den_q});
		q_mag  = sat_q ? VEL_LIMIT : quo_q;
		quot   = neg_q ? -VEL_W'(q_mag) : VEL_W'(q_mag);
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			init_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			init_q <= 1'b1;
		end else if (init_q) begin
			init_q <= 1'b0;
		end else if (busy_q && cnt_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n_full;
			den_q <= den;
			neg_q <= num[SUM_W-1];
			quo_q <= '0;
		end else if (init_q) begin
			sat_q  <= (hi_ext >= den_q);
			rem_q  <= hi_ext;
			nlow_q <= n_q[QBITS-1:0];
			cnt_q  <= 5'(QBITS - 1);
		end else if (busy_q) begin
			rem_q  <= fit ? SUM_W'(trial - {1'b0, den_q}) : SUM_W'(trial);
			quo_q  <= {quo_q[QBITS-2:0], fit};
			nlow_q <= {nlow_q[QBITS-2:0], 1'b0};
			cnt_q  <= cnt_q - 1'b1;
		end
	end

endmodule

/* hdl/odo_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry back end
// Sequencer that scales deltas, reduces the heading, runs the CORDIC, keeps
// the velocity window and integrates the pose into the result register.
// ----------------------------------------------------------------------------
module odo_back
	import odo_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CFG_W-1:0]         dist_per_tick,
	input  logic [CFG_W-1:0]         inv_track_width,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  odo_job_t                 q_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [POS_W-1:0]  pos_x,
	output logic signed [POS_W-1:0]  pos_y,
	output logic signed [HEAD_W-1:0] heading,
	output logic signed [VEL_W-1:0]  vel_linear,
	output logic signed [VEL_W-1:0]  vel_angular
);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W  = TRAVEL_W + $clog2(WINDOW + 1);
	localparam int PROD_W = DELTA_W + CFG_W;
	localparam int HI_W   = (PROD_W - 32) + CFG_W;
	localparam int LO_W   = 32 + CFG_W;
	localparam int TR_W   = 45;
	localparam int MP_W   = TRAVEL_W + CORDIC_W;

	odo_state_t state_q, state_d;
	odo_job_t   job_q;

	logic [PROD_W-1:0]          prod_t_q, prod_d_q;
	logic [HI_W-1:0]            hi_q;
	logic [LO_W-1:0]            lo_q;
	logic signed [TRAVEL_W-1:0] travel_q;
	logic [TURN_MAG_W-1:0]      turn_mag_q;
	logic signed [TURN_MAG_W:0] turn_q;
	logic [ANG_W-1:0]           rmid_q, rnew_q;
	logic                       mneg_q, nneg_q;
	logic [4:0]                 cnt_q;
	logic signed [HEAD_W-1:0]   newh_q;
	logic signed [CORDIC_W-1:0] cx_q, cy_q, cz_q;
	logic                       cneg_q;
	logic [POS_W-1:0]           step_x_q, step_y_q;
	logic [POS_W-1:0]           pose_x_q, pose_y_q;
	logic signed [HEAD_W-1:0]   head_q;
	logic signed [TRAVEL_W-1:0] trav_hist_q [WINDOW];
	logic signed [TRAVEL_W-1:0] turn_hist_q [WINDOW];
	logic [STAMP_W-1:0]         time_hist_q [WINDOW];
	logic [SLOT_W-1:0]          slot_q;
	logic signed [SUM_W-1:0]    sum_t_q, sum_r_q;
	logic [SUM_W-1:0]           sum_dt_q;
	logic                       out_valid_q;
	logic [POS_W-1:0]           out_x_q, out_y_q;
	logic signed [HEAD_W-1:0]   out_h_q;
	logic signed [VEL_W-1:0]    out_vl_q, out_va_q;

	logic [DELTA_W-1:0]         abs_sum, abs_diff;
	logic [PROD_W:0]            t_round, t_shift;
	logic [TRAVEL_W-2:0]        t_mag;
	logic signed [TRAVEL_W-1:0] travel_d;
	logic [LO_W:0]              lo_round;
	logic [TR_W-1:0]            turn_r;
	logic [TURN_MAG_W-1:0]      turn_mag_d;
	logic signed [ANG_W-1:0]    vmid, vnew;
	logic [TURN_MAG_W:0]        tq_round;
	logic signed [TRAVEL_W-1:0] tq16;
	logic [ANG_W-1:0]           wsub;
	logic signed [HEAD_W-1:0]   mid;
	logic signed [CORDIC_W-1:0] mid_ext, dx, dy, atan_a, cos_v, sin_v;
	logic signed [MP_W-1:0]     px, py;
	logic                       div_start, div_busy_t, div_busy_r, div_busy, acc_ok;
	logic signed [VEL_W-1:0]    quot_t, quot_r;

	function automatic logic signed [HEAD_W-1:0] fix_angle(input logic [ANG_W-1:0] r,
		input logic neg);
		logic [ANG_W-1:0] p;
		logic [ANG_W-1:0] s;
		p = (neg && r != '0) ? TWO_PI_U - r : r;
		s = (p > PI_U) ? p - TWO_PI_U : p;
		return s[HEAD_W-1:0];
	endfunction

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		div_busy = div_busy_t || div_busy_r;
		acc_ok   = !div_busy && (!job_q.has_dt || !out_valid_q || out_ready);
		q_pop    = 1'b0;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_PREP;
			ST_PREP: state_d = ST_WRAP;
			ST_WRAP: begin
				if (cnt_q == '0) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: state_d = ST_CORDIC;
			ST_CORDIC: begin
				if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
					state_d = ST_MUL4;
				end
			end
			ST_MUL4: state_d = ST_ACC;
			ST_ACC: begin
				if (acc_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- datapath logic ----------------
	always_comb begin
		abs_sum    = job_q.sum[DELTA_W-1] ? DELTA_W'(-job_q.sum) : DELTA_W'(job_q.sum);
		abs_diff   = job_q.diff[DELTA_W-1] ? DELTA_W'(-job_q.diff) : DELTA_W'(job_q.diff);
		t_round    = {1'b0, prod_t_q} + (PROD_W+1)'(512);
		t_shift    = t_round >> 10;
		t_mag      = (t_shift > (PROD_W+1)'(TRAVEL_LIMIT)) ? TRAVEL_LIMIT
		             : t_shift[TRAVEL_W-2:0];
		travel_d   = job_q.sum[DELTA_W-1] ? -TRAVEL_W'(t_mag) : TRAVEL_W'(t_mag);
		lo_round   = {1'b0, lo_q} + (LO_W+1)'(4096);
		turn_r     = (TR_W'(hi_q[20:0]) << 19) + TR_W'(lo_round >> 13);
		if (hi_q >= HI_W'(2097152) || turn_r > TR_W'(TURN_LIMIT)) begin
			turn_mag_d = TURN_LIMIT;
		end else begin
			turn_mag_d = turn_r[TURN_MAG_W-1:0];
		end
		vmid       = ANG_W'(head_q) + ANG_W'(turn_q >>> 1);
		vnew       = ANG_W'(head_q) + ANG_W'(turn_q);
		tq_round   = {1'b0, turn_mag_q} + (TURN_MAG_W+1)'(2048);
		tq16       = turn_q[TURN_MAG_W] ? -TRAVEL_W'(tq_round[TURN_MAG_W:12])
		             : TRAVEL_W'(tq_round[TURN_MAG_W:12]);
		wsub       = TWO_PI_U << cnt_q;
		mid        = fix_angle(rmid_q, mneg_q);
		mid_ext    = CORDIC_W'(mid);
		dx         = cy_q >>> cnt_q;
		dy         = cx_q >>> cnt_q;
		atan_a     = atan_step(cnt_q);
		cos_v      = cneg_q ? -cx_q : cx_q;
		sin_v      = cneg_q ? -cy_q : cy_q;
		px         = (MP_W'(travel_q) * MP_W'(cos_v)) + MP_W'(64'sd536870912);
		py         = (MP_W'(travel_q) * MP_W'(sin_v)) + MP_W'(64'sd536870912);
		div_start  = (state_q == ST_WRAP) && (cnt_q == 5'(WRAP_STEPS - 1)) && job_q.has_dt;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					job_q <= q_data;
				end
			end
			ST_MUL1: begin
				prod_t_q <= PROD_W'(abs_sum) * PROD_W'(dist_per_tick);
				prod_d_q <= PROD_W'(abs_diff) * PROD_W'(dist_per_tick);
			end
			ST_MUL2: begin
				travel_q <= travel_d;
				hi_q     <= HI_W'(prod_d_q[PROD_W-1:32]) * HI_W'(inv_track_width);
				lo_q     <= LO_W'(prod_d_q[31:0]) * LO_W'(inv_track_width);
			end
			ST_MUL3: begin
				turn_mag_q <= turn_mag_d;
				turn_q     <= job_q.diff[DELTA_W-1] ? -(TURN_MAG_W+1)'(turn_mag_d)
				              : (TURN_MAG_W+1)'(turn_mag_d);
			end
			ST_PREP: begin
				rmid_q <= vmid[ANG_W-1] ? ANG_W'(-vmid) : ANG_W'(vmid);
				mneg_q <= vmid[ANG_W-1];
				rnew_q <= vnew[ANG_W-1] ? ANG_W'(-vnew) : ANG_W'(vnew);
				nneg_q <= vnew[ANG_W-1];
				cnt_q  <= 5'(WRAP_STEPS - 1);
			end
			ST_WRAP: begin
				if (rmid_q >= wsub) begin
					rmid_q <= rmid_q - wsub;
				end
				if (rnew_q >= wsub) begin
					rnew_q <= rnew_q - wsub;
				end
				cnt_q <= cnt_q - 1'b1;
			end
			ST_FOLD: begin
				newh_q <= fix_angle(rnew_q, nneg_q);
				cx_q   <= CORDIC_K;
				cy_q   <= '0;
				cnt_q  <= '0;
				if (mid_ext > HALF_PI_C) begin
					cz_q   <= mid_ext - PI_C;
					cneg_q <= 1'b1;
				end else if (mid_ext < -HALF_PI_C) begin
					cz_q   <= mid_ext + PI_C;
					cneg_q <= 1'b1;
				end else begin
					cz_q   <= mid_ext;
					cneg_q <= 1'b0;
				end
			end
			ST_CORDIC: begin
				if (cz_q >= 0) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - atan_a;
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + atan_a;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			ST_MUL4: begin
				step_x_q <= px[61:30];
				step_y_q <= py[61:30];
			end
			ST_ACC: begin
				if (acc_ok && job_q.has_dt) begin
					out_x_q  <= pose_x_q + step_x_q;
					out_y_q  <= pose_y_q + step_y_q;
					out_h_q  <= newh_q;
					out_vl_q <= quot_t;
					out_va_q <= quot_r;
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------- pose, window and result flag ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			head_q      <= '0;
			slot_q      <= '0;
			sum_t_q     <= '0;
			sum_r_q     <= '0;
			sum_dt_q    <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WINDOW; i++) begin
				trav_hist_q[i] <= '0;
				turn_hist_q[i] <= '0;
				time_hist_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_PREP && job_q.has_dt) begin
				trav_hist_q[slot_q] <= travel_q;
				turn_hist_q[slot_q] <= tq16;
				time_hist_q[slot_q] <= job_q.dt;
				sum_t_q  <= sum_t_q - SUM_W'(trav_hist_q[slot_q]) + SUM_W'(travel_q);
				sum_r_q  <= sum_r_q - SUM_W'(turn_hist_q[slot_q]) + SUM_W'(tq16);
				sum_dt_q <= sum_dt_q - SUM_W'(time_hist_q[slot_q]) + SUM_W'(job_q.dt);
				slot_q   <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			end
			if (state_q == ST_ACC && acc_ok) begin
				pose_x_q <= pose_x_q + step_x_q;
				pose_y_q <= pose_y_q + step_y_q;
				head_q   <= newh_q;
			end
			if (state_q == ST_ACC && acc_ok && job_q.has_dt) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	odo_div #(
		.SUM_W(SUM_W)
	) u_div_lin (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_t_q),
		.den    (sum_dt_q),
		.busy   (div_busy_t),
		.quot   (quot_t)
	);

	odo_div #(
		.SUM_W(SUM_W)
	) u_div_ang (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_r_q),
		.den    (sum_dt_q),
		.busy   (div_busy_r),
		.quot   (quot_r)
	);

	assign out_valid   = out_valid_q;
	assign pos_x       = out_x_q;
	assign pos_y       = out_y_q;
	assign heading     = out_h_q;
	assign vel_linear  = out_vl_q;
	assign vel_angular = out_va_q;

	a_div_done_at_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL4) |=> !div_busy)
		else $error("velocity divider still busy at pose update");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		(HEAD_W+1)'(head_q) <= (HEAD_W+1)'(PI_C) && (HEAD_W+1)'(head_q) >= -(HEAD_W+1)'(PI_C))
		else $error("heading outside plus or minus pi");

	a_result_needs_dt: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_ACC && job_q.has_dt))
		else $error("result raised without a nonzero time delta");

endmodule

/* hdl/wheel_odometry_integrator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel odometry integrator
// Differential drive odometry: wheel ticks and time in, pose and windowed
// velocity out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes four absolute tick counts and a
// microsecond stamp. The first request after reset only latches counts and
// time. Each later request updates the pose; it yields a result on the
// output channel (out_valid/out_ready) unless its time delta is zero.
// The back end works on one request at a time; the 11-step heading
// reduction and the 28-step CORDIC run back to back on its sequencer. The
// velocity dividers start during the heading reduction and run alongside
// the CORDIC.
// A two-entry queue lets the front end take requests while the back end
// works. When the receiver stalls, the result register holds; the back end
// finishes the next request and waits at its pose update, then the queue
// fills and in_ready drops.
// Reset clears the pose, the velocity window and the registers to their
// defaults; configuration is written through cfg_write/cfg_index/cfg_data.
// The user must write it only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module wheel_odometry_integrator_top
	import odo_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [TICK_W-1:0] ticks_front_left,
	input  logic signed [TICK_W-1:0] ticks_rear_left,
	input  logic signed [TICK_W-1:0] ticks_front_right,
	input  logic signed [TICK_W-1:0] ticks_rear_right,
	input  logic [STAMP_W-1:0]       stamp_us,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [POS_W-1:0]  pos_x,
	output logic signed [POS_W-1:0]  pos_y,
	output logic signed [HEAD_W-1:0] heading,
	output logic signed [VEL_W-1:0]  vel_linear,
	output logic signed [VEL_W-1:0]  vel_angular
);

	logic [CFG_W-1:0] dist_per_tick_q, inv_track_width_q;
	logic             q_push, q_full, q_pop, q_empty;
	odo_job_t         q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_per_tick_q   <= DIST_PER_TICK_RST;
			inv_track_width_q <= INV_TRACK_WIDTH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DIST_PER_TICK:   dist_per_tick_q   <= cfg_data;
				REG_INV_TRACK_WIDTH: inv_track_width_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	odo_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.ticks_front_left  (ticks_front_left),
		.ticks_rear_left   (ticks_rear_left),
		.ticks_front_right (ticks_front_right),
		.ticks_rear_right  (ticks_rear_right),
		.stamp_us          (stamp_us),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_data            (q_wdata)
	);

	odo_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	odo_back #(
		.WINDOW(WINDOW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.dist_per_tick   (dist_per_tick_q),
		.inv_track_width (inv_track_width_q),
		.q_empty         (q_empty),
		.q_pop           (q_pop),
		.q_data          (q_rdata),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.heading         (heading),
		.vel_linear      (vel_linear),
		.vel_angular     (vel_angular)
	);

endmodule
